>>> rtl/nqps_pkg.sv
// nqps_pkg: shared constants, types and helper functions for the N-queens
// permutation search. No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package nqps_pkg;

  localparam int MAX_QUEENS = 8;
  localparam int IDX_W      = $clog2(MAX_QUEENS);
  localparam int N_W        = $clog2(MAX_QUEENS + 1);
  localparam int DIAG_N     = 2 * MAX_QUEENS - 1;
  localparam int DIAG_W     = $clog2(DIAG_N);
  localparam int PACK_COLS  = (MAX_QUEENS < 8) ? MAX_QUEENS : 8;
  localparam int ARR_W      = 32;
  localparam int CNT_W      = 16;
  localparam int BS_W       = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 1'b1;

  localparam logic [BS_W-1:0]  BOARD_SIZE_RST = 4'd8;
  localparam logic [CNT_W-1:0] TARGET_RST     = 16'd92;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } perm_wr_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] last_col;
  } seq_cmd_t;

  typedef struct packed {
    logic done;
    logic sol;
    logic wrapped;
  } seq_rsp_t;

  // board size as used: 0 acts as 1, anything above the maximum is clamped
  function automatic logic [N_W-1:0] eff_n(input logic [BS_W-1:0] bs);
    logic [N_W-1:0] r;
    if (bs == '0) begin
      r = N_W'(1);
    end else if (int'(bs) > MAX_QUEENS) begin
      r = N_W'(MAX_QUEENS);
    end else begin
      r = N_W'(bs);
    end
    return r;
  endfunction

  // nibbles of the columns in use
  function automatic logic [ARR_W-1:0] arr_mask(input logic [N_W-1:0] n);
    logic [ARR_W-1:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < int'(n)) begin
        m[4*k +: 4] = 4'hF;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/nqps_perm.sv
// nqps_perm: permutation store, one read and one write port, restart to identity.
// Depends on nqps_pkg.
`timescale 1ns / 1ps

module nqps_perm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             restart_i,
  input  nqps_pkg::perm_wr_t               wr_i,
  input  logic [nqps_pkg::IDX_W-1:0]       raddr_i,
  output logic [nqps_pkg::IDX_W-1:0]       rdata_o,
  output logic [nqps_pkg::ARR_W-1:0]       packed_o
);

  logic [nqps_pkg::IDX_W-1:0] perm_q [nqps_pkg::MAX_QUEENS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < nqps_pkg::MAX_QUEENS; k++) begin
        perm_q[k] <= nqps_pkg::IDX_W'(k);
      end
    end else if (restart_i) begin
      for (int k = 0; k < nqps_pkg::MAX_QUEENS; k++) begin
        perm_q[k] <= nqps_pkg::IDX_W'(k);
      end
    end else if (wr_i.we) begin
      perm_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = perm_q[raddr_i];

  always_comb begin
    packed_o = '0;
    for (int k = 0; k < nqps_pkg::PACK_COLS; k++) begin
      packed_o[4*k +: 4] = 4'(perm_q[k]);
    end
  end

endmodule

>>> rtl/nqps_seq.sv
// nqps_seq: sequencer with one shared comparator; tests the held permutation
// column by column, then advances it in place. Depends on nqps_pkg.
`timescale 1ns / 1ps

module nqps_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nqps_pkg::seq_cmd_t          cmd_i,
  output nqps_pkg::seq_rsp_t          rsp_o,
  output logic [nqps_pkg::IDX_W-1:0]  raddr_o,
  input  logic [nqps_pkg::IDX_W-1:0]  rdata_i,
  output nqps_pkg::perm_wr_t          wr_o
);

  localparam int IW = nqps_pkg::IDX_W;
  localparam int DW = nqps_pkg::DIAG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_FI0  = 4'd2;
  localparam logic [3:0] S_FI   = 4'd3;
  localparam logic [3:0] S_FJ   = 4'd4;
  localparam logic [3:0] S_SA   = 4'd5;
  localparam logic [3:0] S_SB   = 4'd6;
  localparam logic [3:0] S_SC   = 4'd7;
  localparam logic [3:0] S_RV   = 4'd8;
  localparam logic [3:0] S_END  = 4'd9;

  logic [3:0]                    state_q, state_d;
  logic [IW-1:0]                 cur_q, cur_d;
  logic [IW-1:0]                 lo_q, lo_d;
  logic [IW-1:0]                 hi_q, hi_d;
  logic [IW-1:0]                 i_q, i_d;
  logic [IW-1:0]                 val_q, val_d;
  logic [IW-1:0]                 pivot_q, pivot_d;
  logic                          rev_q, rev_d;
  logic                          sol_q, sol_d;
  logic                          wrap_q, wrap_d;
  logic [nqps_pkg::DIAG_N-1:0]   up_q, up_d;
  logic [nqps_pkg::DIAG_N-1:0]   dn_q, dn_d;

  logic [IW-1:0] cmp_a, cmp_b;
  logic          ge;
  logic [DW-1:0] u_idx, d_idx;

  // shared comparator
  assign ge = (cmp_a >= cmp_b);

  assign u_idx = DW'(cur_q) + DW'(rdata_i);
  assign d_idx = DW'(cur_q) + DW'(nqps_pkg::MAX_QUEENS - 1) - DW'(rdata_i);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    i_d     = i_q;
    val_d   = val_q;
    pivot_d = pivot_q;
    rev_d   = rev_q;
    sol_d   = sol_q;
    wrap_d  = wrap_q;
    up_d    = up_q;
    dn_d    = dn_q;
    cmp_a   = cur_q;
    cmp_b   = cmd_i.last_col;
    raddr_o = cur_q;
    wr_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.start) begin
          up_d    = '0;
          dn_d    = '0;
          cur_d   = '0;
          sol_d   = 1'b0;
          wrap_d  = 1'b0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (up_q[u_idx] || dn_q[d_idx]) begin
          sol_d   = 1'b0;
          state_d = (cmd_i.last_col == '0) ? S_END : S_FI0;
          wrap_d  = (cmd_i.last_col == '0);
        end else begin
          up_d[u_idx] = 1'b1;
          dn_d[d_idx] = 1'b1;
          if (ge) begin
            sol_d   = 1'b1;
            state_d = (cmd_i.last_col == '0) ? S_END : S_FI0;
            wrap_d  = (cmd_i.last_col == '0);
          end else begin
            cur_d = cur_q + 1'b1;
          end
        end
      end
      S_FI0: begin
        raddr_o = cmd_i.last_col;
        val_d   = rdata_i;
        cur_d   = cmd_i.last_col;
        state_d = S_FI;
      end
      S_FI: begin
        raddr_o = (cur_q == '0) ? '0 : cur_q - 1'b1;
        cmp_a   = rdata_i;
        cmp_b   = val_q;
        if (cur_q == '0) begin
          // last permutation: reverse the whole board back to identity
          wrap_d  = 1'b1;
          lo_d    = '0;
          hi_d    = cmd_i.last_col;
          rev_d   = 1'b1;
          state_d = S_RV;
        end else if (ge) begin
          val_d = rdata_i;
          cur_d = cur_q - 1'b1;
        end else begin
          pivot_d = rdata_i;
          i_d     = cur_q;
          cur_d   = cmd_i.last_col;
          state_d = S_FJ;
        end
      end
      S_FJ: begin
        raddr_o = cur_q;
        cmp_a   = pivot_q;
        cmp_b   = rdata_i;
        if (ge) begin
          cur_d = cur_q - 1'b1;
        end else begin
          lo_d    = i_q - 1'b1;
          hi_d    = cur_q;
          rev_d   = 1'b0;
          state_d = S_SA;
        end
      end
      S_SA: begin
        raddr_o = lo_q;
        val_d   = rdata_i;
        state_d = S_SB;
      end
      S_SB: begin
        raddr_o  = hi_q;
        wr_o.we   = 1'b1;
        wr_o.addr = lo_q;
        wr_o.data = rdata_i;
        state_d  = S_SC;
      end
      S_SC: begin
        wr_o.we   = 1'b1;
        wr_o.addr = hi_q;
        wr_o.data = val_q;
        if (rev_q) begin
          lo_d = lo_q + 1'b1;
          hi_d = hi_q - 1'b1;
        end else begin
          lo_d  = i_q;
          hi_d  = cmd_i.last_col;
          rev_d = 1'b1;
        end
        state_d = S_RV;
      end
      S_RV: begin
        cmp_a   = lo_q;
        cmp_b   = hi_q;
        state_d = ge ? S_END : S_SA;
      end
      S_END: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.done    = (state_q == S_END);
  assign rsp_o.sol     = sol_q;
  assign rsp_o.wrapped = wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    val_q   <= val_d;
    pivot_q <= pivot_d;
    rev_q   <= rev_d;
    sol_q   <= sol_d;
    wrap_q  <= wrap_d;
    up_q    <= up_d;
    dn_q    <= dn_d;
  end

  a_marks_paired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> ($countones(up_q) == $countones(dn_q)))
    else $error("diagonal marks out of step");

  a_j_not_below_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FJ) |-> (cur_q >= i_q))
    else $error("successor search ran past the pivot");

  a_write_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (wr_o.addr <= cmd_i.last_col))
    else $error("permutation write outside the board");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("completion held for more than one cycle");

endmodule

>>> rtl/n_queens_permutation_search.sv
// Search: one column per cycle in the check and suffix scans; each swap reads both entries, writes
// both ends and compares the bounds. Throughput: one item at a time; the next transfer is taken once
// the result is registered, later while the output register stays full. Reset: asynchronous, active
// low; identity permutation, count zero, board_size 8, target_solutions 92. Uses nqps_perm, nqps_seq.
`timescale 1ns / 1ps

module n_queens_permutation_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                was_solution_o,
  output logic [nqps_pkg::ARR_W-1:0]          arrangement_o,
  output logic [nqps_pkg::CNT_W-1:0]          solution_count_o,
  output logic                                finished_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nqps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nqps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                   st_q, st_d;
  logic [nqps_pkg::N_W-1:0]     n_q;
  logic [nqps_pkg::CNT_W-1:0]   target_q;
  logic [nqps_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         done_q, done_d;
  logic                         sol_q, sol_d;
  logic                         wrap_q, wrap_d;
  logic [nqps_pkg::ARR_W-1:0]   arr_q, arr_d;
  logic                         out_valid_q;
  logic                         out_sol_q;
  logic [nqps_pkg::ARR_W-1:0]   out_arr_q;
  logic [nqps_pkg::CNT_W-1:0]   out_cnt_q;
  logic                         out_fin_q;

  logic                         in_xfer, out_xfer, cfg_xfer, bs_we, tgt_we;
  logic                         restart;
  logic                         tgt_hit, done_next, out_load;
  nqps_pkg::seq_cmd_t           cmd;
  nqps_pkg::seq_rsp_t           rsp;
  nqps_pkg::perm_wr_t           wr;
  logic [nqps_pkg::IDX_W-1:0]   raddr, rdata;
  logic [nqps_pkg::ARR_W-1:0]   perm_word;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign bs_we       = cfg_xfer && (cfg_index_i == nqps_pkg::CFG_BOARD_SIZE);
  assign tgt_we      = cfg_xfer && (cfg_index_i == nqps_pkg::CFG_TARGET);
  assign restart     = (in_xfer && restart_i) || bs_we;

  assign tgt_hit   = (target_q != '0) && (count_q >= target_q);
  assign done_next = done_q || wrap_q || tgt_hit;
  assign out_load  = (st_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign cmd.start    = (st_q == ST_PREP) && !(done_q || tgt_hit);
  assign cmd.last_col = nqps_pkg::IDX_W'(n_q - 1'b1);

  nqps_perm u_perm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .wr_i      (wr),
    .raddr_i   (raddr),
    .rdata_o   (rdata),
    .packed_o  (perm_word)
  );

  nqps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rsp_o   (rsp),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .wr_o    (wr)
  );

  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    done_d  = done_q;
    sol_d   = sol_q;
    wrap_d  = wrap_q;
    arr_d   = arr_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (restart_i) begin
            count_d = '0;
            done_d  = 1'b0;
          end
          st_d = ST_PREP;
        end
      end
      ST_PREP: begin
        arr_d  = perm_word & nqps_pkg::arr_mask(n_q);
        sol_d  = 1'b0;
        wrap_d = 1'b0;
        if (done_q || tgt_hit) begin
          done_d = 1'b1;
          st_d   = ST_OUT;
        end else begin
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rsp.done) begin
          sol_d  = rsp.sol;
          wrap_d = rsp.wrapped;
          if (rsp.sol && (count_q != '1)) begin
            count_d = count_q + 1'b1;
          end
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          done_d = done_next;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (bs_we) begin
      count_d = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      n_q         <= nqps_pkg::eff_n(nqps_pkg::BOARD_SIZE_RST);
      target_q    <= nqps_pkg::TARGET_RST;
      count_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (bs_we) begin
        n_q <= nqps_pkg::eff_n(cfg_data_i[nqps_pkg::BS_W-1:0]);
      end
      if (tgt_we) begin
        target_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sol_q  <= sol_d;
    wrap_q <= wrap_d;
    arr_q  <= arr_d;
    if (out_load) begin
      out_sol_q <= sol_q;
      out_arr_q <= arr_q;
      out_cnt_q <= count_q;
      out_fin_q <= done_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign was_solution_o   = out_sol_q;
  assign arrangement_o    = out_arr_q;
  assign solution_count_o = out_cnt_q;
  assign finished_o       = out_fin_q;

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !restart) |=> done_q)
    else $error("finished flag dropped without restart");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
              count_q == '0))
    else $error("solution count jumped");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT && out_valid_q && out_stall_i) |=> (st_q == ST_OUT))
    else $error("result left the output stage while the register was full");

endmodule
